[rtl/core/grwc_pkg.sv]
package grwc_pkg;

   // Default sizes of the raycaster.
   localparam int NUM_RAYS_DEF  = 60;
   localparam int MAX_STEPS_DEF = 8;
   localparam int MAP_SIDE_DEF  = 8;
   localparam int CELL_SIZE_DEF = 64;

   // Field widths of the channels.
   localparam int POS_W  = 13;
   localparam int ANG_W  = 13;
   localparam int COL_W  = 6;
   localparam int SIDE_W = 2;
   localparam int DIST_W = 14;
   localparam int HGT_W  = 9;
   localparam int TOP_W  = 8;

   // Internal datapath widths, sized for the whole parameter range.
   localparam int XY_W   = 19;
   localparam int Z_W    = 21;
   localparam int LINE_W = 19;
   localparam int DIF_W  = 20;
   localparam int PROD_W = 39;
   localparam int DIV_W  = 38;
   localparam int DVS_W  = 17;
   localparam int O_W    = 40;
   localparam int HIT_W  = 17;
   localparam int LIDX_W = 8;
   localparam int SQ_W   = 32;

   localparam logic [63:0] WALL_MAP_RESET = 64'd18411139144960280063;

   // Angles in sixteenths of a degree.
   localparam logic [ANG_W-1:0] FULL_TURN     = 13'd5760;
   localparam logic [ANG_W-1:0] QUARTER_TURN  = 13'd1440;
   localparam logic [ANG_W-1:0] HALF_TURN     = 13'd2880;
   localparam logic [ANG_W-1:0] THREE_QUARTER = 13'd4320;
   localparam logic [ANG_W-1:0] RAY_START     = 13'd5280;
   localparam logic [ANG_W-1:0] RAY_STEP      = 13'd16;

   // Wall side codes.
   localparam logic [SIDE_W-1:0] SIDE_VERT = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_HORZ = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd2;

   localparam logic [DIST_W-1:0] DIST_MAX    = 14'd16383;
   localparam logic [HGT_W-1:0]  HEIGHT_MAX  = 9'd320;
   localparam logic [TOP_W-1:0]  HALF_SCREEN = 8'd160;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 19'sd39797;

   // CORDIC arc table in 1/4096 degree.
   function automatic logic signed [Z_W-1:0] arc_val(input logic [3:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         4'd0:    v = 21'sd184320;
         4'd1:    v = 21'sd108810;
         4'd2:    v = 21'sd57492;
         4'd3:    v = 21'sd29184;
         4'd4:    v = 21'sd14649;
         4'd5:    v = 21'sd7331;
         4'd6:    v = 21'sd3667;
         4'd7:    v = 21'sd1833;
         4'd8:    v = 21'sd917;
         4'd9:    v = 21'sd458;
         4'd10:   v = 21'sd229;
         4'd11:   v = 21'sd115;
         4'd12:   v = 21'sd57;
         4'd13:   v = 21'sd29;
         4'd14:   v = 21'sd14;
         default: v = 21'sd7;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/grwc_req_if.sv]
interface grwc_req_if import grwc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] view_x;
   logic [POS_W-1:0] view_y;
   logic [ANG_W-1:0] heading;

   modport source(output valid, output view_x, output view_y, output heading, input ready);
   modport sink(input valid, input view_x, input view_y, input heading, output ready);
endinterface

[rtl/core/grwc_rsp_if.sv]
interface grwc_rsp_if import grwc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  column;
   logic [SIDE_W-1:0] wall_side;
   logic [POS_W-1:0]  hit_x;
   logic [POS_W-1:0]  hit_y;
   logic [DIST_W-1:0] corrected_distance;
   logic [HGT_W-1:0]  wall_height;
   logic [TOP_W-1:0]  wall_top;
   logic              last;

   modport source(output valid, output column, output wall_side, output hit_x, output hit_y,
                  output corrected_distance, output wall_height, output wall_top,
                  output last, input ready);
   modport sink(input valid, input column, input wall_side, input hit_x, input hit_y,
                input corrected_distance, input wall_height, input wall_top,
                input last, output ready);
endinterface

[rtl/core/grwc_div.sv]
module grwc_div import grwc_pkg::*; #(
   parameter int DIVIDEND_W = DIV_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DVS_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]        trial;
   logic                  fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/grid_raycast_wall_columns.sv]
// Grid raycaster that turns one view request into a frame of wall columns.
// The req channel carries the player position and heading; one item there
// yields NUM_RAYS items on the rsp channel, one per screen column, left to
// right, the final one flagged by last. csr_wr_en with csr_wr_data loads the
// 64-bit wall bitmap; write it only while no frame is in flight.
// A column runs through one sequencer: a CORDIC for the ray angle, two grid
// walks of at most MAX_STEPS lines where each line in the map costs one
// multiply and a 38-step shared divider, then, for a ray with a hit, the
// squaring states S_DHX to S_DVY, a square root, a second CORDIC for the
// fisheye cosine and one more divider pass for the height unless the
// corrected distance is zero. A ray that meets nothing goes from the walks
// on to the output state. req ready is high only between frames.
// Each column sits in an output register; when the receiver stalls, the block
// waits with the next column until that register drains.
// Reset (synchronous) returns to idle, drops rsp valid and reloads the
// bordered demo room into the wall bitmap.
module grid_raycast_wall_columns import grwc_pkg::*; #(
   parameter int NUM_RAYS  = NUM_RAYS_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF,
   parameter int MAP_SIDE  = MAP_SIDE_DEF,
   parameter int CELL_SIZE = CELL_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   grwc_req_if.sink    req,
   grwc_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   localparam int CELL_FIX   = CELL_SIZE * 16;
   localparam int IDX_MAX    = 8191 / CELL_FIX;
   localparam int MAP_SPAN   = MAP_SIDE * CELL_FIX;
   localparam int HEIGHT_NUM = CELL_SIZE * 320 * 16;
   localparam int K_W        = $clog2(MAX_STEPS + 1);

   // Sequencer states.
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CORD   = 5'd1;
   localparam logic [4:0] S_HSET   = 5'd2;
   localparam logic [4:0] S_VSET   = 5'd3;
   localparam logic [4:0] S_WSTEP  = 5'd4;
   localparam logic [4:0] S_WMUL   = 5'd5;
   localparam logic [4:0] S_WDIVGO = 5'd6;
   localparam logic [4:0] S_WDIV   = 5'd7;
   localparam logic [4:0] S_WCHK   = 5'd8;
   localparam logic [4:0] S_DHX    = 5'd9;
   localparam logic [4:0] S_DHY    = 5'd10;
   localparam logic [4:0] S_DVX    = 5'd11;
   localparam logic [4:0] S_DVY    = 5'd12;
   localparam logic [4:0] S_PICK   = 5'd13;
   localparam logic [4:0] S_SQRT   = 5'd14;
   localparam logic [4:0] S_FISH   = 5'd15;
   localparam logic [4:0] S_CMUL   = 5'd16;
   localparam logic [4:0] S_CORR   = 5'd17;
   localparam logic [4:0] S_HDIV   = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   logic [4:0]               state_ff, state_in;
   logic [63:0]              wall_map_ff;
   logic [POS_W-1:0]         px_ff, px_in, py_ff, py_in;
   logic [ANG_W-1:0]         h_ff, h_in, ra_ff, ra_in;
   logic [COL_W-1:0]         ray_ff, ray_in;
   logic signed [XY_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]    cz_ff, cz_in;
   logic [1:0]               cq_ff, cq_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic                     csel_ff, csel_in;
   logic signed [XY_W-1:0]   c_ff, c_in, s_ff, s_in, fc_ff, fc_in;
   logic [POS_W-1:0]         w_pm_ff, w_pm_in, w_po_ff, w_po_in;
   logic signed [XY_W-1:0]   w_num_ff, w_num_in, w_den_ff, w_den_in;
   logic                     w_fwd_ff, w_fwd_in, w_horiz_ff, w_horiz_in, w_neg_ff, w_neg_in;
   logic signed [LINE_W-1:0] w_line_ff, w_line_in;
   logic signed [LIDX_W-1:0] w_l_ff, w_l_in;
   logic [K_W-1:0]           w_k_ff, w_k_in;
   logic signed [O_W-1:0]    o_ff, o_in;
   logic                     hh_ff, hh_in, vh_ff, vh_in;
   logic [HIT_W-1:0]         hx_ff, hx_in, hy_ff, hy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SQ_W-1:0]          acc_ff, acc_in, dh_ff, dh_in;
   logic [SQ_W-1:0]          sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [SIDE_W-1:0]        res_side_ff, res_side_in;
   logic [HIT_W-1:0]         res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [DIST_W-1:0]        res_corr_ff, res_corr_in;
   logic [HGT_W-1:0]         res_h_ff, res_h_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]         rsp_column_ff;
   logic [SIDE_W-1:0]        rsp_side_ff;
   logic [POS_W-1:0]         rsp_x_ff, rsp_y_ff;
   logic [DIST_W-1:0]        rsp_corr_ff;
   logic [HGT_W-1:0]         rsp_h_ff;
   logic [TOP_W-1:0]         rsp_top_ff;
   logic                     rsp_last_ff;

   // Combinational helpers.
   logic                     accept, load, do_adv, ray_start, cord_go;
   logic [ANG_W-1:0]         h_wrap, ra_first, ra_next, fish_ang, cord_ang, cord_part;
   logic [ANG_W:0]           sum14;
   logic [1:0]               cord_q;
   logic signed [XY_W-1:0]   shx, shy, nx, ny, fold_c, fold_s;
   logic signed [Z_W-1:0]    nz, arc;
   logic [POS_W-1:0]         ws_pm;
   logic                     ws_fwd;
   logic [4:0]               ws_idx;
   logic signed [LIDX_W-1:0] w_cm;
   logic                     cm_ok, o_ok, wall_bit;
   logic [2:0]               chk_cc;
   logic [5:0]               bit_idx;
   logic signed [DIF_W-1:0]  mul_a;
   logic signed [XY_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p, prod_abs;
   logic signed [XY_W-1:0]   den_abs;
   logic signed [O_W-1:0]    q_signed;
   logic signed [HIT_W:0]    d_hx, d_hy, d_vx, d_vy;
   logic [SQ_W-1:0]          dv;
   logic [SQ_W:0]            sq_trial;
   logic [PROD_W-17:0]       corr_wide;
   logic [DIST_W-1:0]        corr_val;
   logic                     div_start, div_done;
   logic [DIV_W-1:0]         div_dividend, div_quo;
   logic [DVS_W-1:0]         div_divisor;
   logic [POS_W-1:0]         def_x, def_y;

   grwc_div #(.DIVIDEND_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   // Angle bookkeeping: heading wrap, ray angles and fisheye angle.
   always_comb begin
      h_wrap   = (req.heading >= FULL_TURN) ? ANG_W'(req.heading - FULL_TURN) : req.heading;
      sum14    = {1'b0, h_wrap} + {1'b0, RAY_START};
      ra_first = (sum14 >= {1'b0, FULL_TURN}) ? ANG_W'(sum14 - {1'b0, FULL_TURN})
                                              : sum14[ANG_W-1:0];
      ra_next  = (ra_ff + RAY_STEP >= FULL_TURN) ? ANG_W'(ra_ff + RAY_STEP - FULL_TURN)
                                                 : ANG_W'(ra_ff + RAY_STEP);
      fish_ang = (h_ff >= ra_ff) ? ANG_W'(h_ff - ra_ff) : ANG_W'(h_ff + FULL_TURN - ra_ff);
   end

   // CORDIC launch angle and quadrant split.
   always_comb begin
      ray_start = accept || (load && (ray_ff != COL_W'(NUM_RAYS - 1)));
      cord_go   = ray_start || (state_ff == S_FISH);
      if (state_ff == S_IDLE)      cord_ang = ra_first;
      else if (state_ff == S_FISH) cord_ang = fish_ang;
      else                         cord_ang = ra_next;
      if (cord_ang < QUARTER_TURN) begin
         cord_q = 2'd0; cord_part = cord_ang;
      end else if (cord_ang < HALF_TURN) begin
         cord_q = 2'd1; cord_part = ANG_W'(cord_ang - QUARTER_TURN);
      end else if (cord_ang < THREE_QUARTER) begin
         cord_q = 2'd2; cord_part = ANG_W'(cord_ang - HALF_TURN);
      end else begin
         cord_q = 2'd3; cord_part = ANG_W'(cord_ang - THREE_QUARTER);
      end
   end

   // One CORDIC rotation and the quadrant fold of its result.
   always_comb begin
      shx = cx_ff >>> cnt_ff;
      shy = cy_ff >>> cnt_ff;
      arc = arc_val(cnt_ff);
      if (!cz_ff[Z_W-1]) begin
         nx = cx_ff - shy; ny = cy_ff + shx; nz = cz_ff - arc;
      end else begin
         nx = cx_ff + shy; ny = cy_ff - shx; nz = cz_ff + arc;
      end
      case (cq_ff)
         2'd0:    begin fold_c = nx;  fold_s = ny;  end
         2'd1:    begin fold_c = -ny; fold_s = nx;  end
         2'd2:    begin fold_c = -nx; fold_s = -ny; end
         default: begin fold_c = ny;  fold_s = -nx; end
      endcase
   end

   // Walk setup: cell of the player along the main axis.
   always_comb begin
      ws_pm  = (state_ff == S_HSET) ? py_ff : px_ff;
      ws_fwd = (state_ff == S_HSET) ? (ra_ff < HALF_TURN)
                                    : ((ra_ff < QUARTER_TURN) || (ra_ff > THREE_QUARTER));
      ws_idx = '0;
      for (int k = 1; k <= IDX_MAX; k++) begin
         if (32'(ws_pm) >= 32'(k * CELL_FIX)) ws_idx = ws_idx + 1'b1;
      end
   end

   // Grid line test: cell on the main axis, crossing cell and wall bit.
   always_comb begin
      w_cm   = w_fwd_ff ? w_l_ff : w_l_ff - LIDX_W'(1);
      cm_ok  = (w_cm >= 0) && (w_cm < LIDX_W'(MAP_SIDE));
      o_ok   = (o_ff >= 0) && (o_ff < O_W'(MAP_SPAN));
      chk_cc = '0;
      for (int k = 1; k < MAP_SIDE; k++) begin
         if (o_ff >= O_W'(k * CELL_FIX)) chk_cc = chk_cc + 1'b1;
      end
      bit_idx  = w_horiz_ff ? {w_cm[2:0], chk_cc} : {chk_cc, w_cm[2:0]};
      wall_bit = wall_map_ff[bit_idx];
   end

   // Shared multiplier operands.
   always_comb begin
      d_hx = $signed({1'b0, hx_ff}) - $signed({5'b0, px_ff});
      d_hy = $signed({1'b0, hy_ff}) - $signed({5'b0, py_ff});
      d_vx = $signed({1'b0, vx_ff}) - $signed({5'b0, px_ff});
      d_vy = $signed({1'b0, vy_ff}) - $signed({5'b0, py_ff});
      case (state_ff)
         S_WMUL: begin
            mul_a = DIF_W'(w_line_ff) - $signed({7'b0, w_pm_ff});
            mul_b = w_num_ff;
         end
         S_DHX:  begin mul_a = DIF_W'(d_hx); mul_b = XY_W'(d_hx); end
         S_DHY:  begin mul_a = DIF_W'(d_hy); mul_b = XY_W'(d_hy); end
         S_DVX:  begin mul_a = DIF_W'(d_vx); mul_b = XY_W'(d_vx); end
         S_DVY:  begin mul_a = DIF_W'(d_vy); mul_b = XY_W'(d_vy); end
         default: begin
            mul_a = $signed({4'b0, sres_ff[15:0]});
            mul_b = fc_ff;
         end
      endcase
      mul_p    = mul_a * mul_b;
      prod_abs = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      den_abs  = w_den_ff[XY_W-1] ? -w_den_ff : w_den_ff;
      q_signed = w_neg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
   end

   // Divider requests: crossing offset or wall height.
   always_comb begin
      corr_wide = prod_ff[PROD_W-1:16];
      if (fc_ff <= 0)                            corr_val = '0;
      else if (corr_wide > (PROD_W-16)'(DIST_MAX)) corr_val = DIST_MAX;
      else                                       corr_val = corr_wide[DIST_W-1:0];
      div_start = (state_ff == S_WDIVGO) || ((state_ff == S_CORR) && (corr_val != '0));
      if (state_ff == S_WDIVGO) begin
         div_dividend = prod_abs[DIV_W-1:0];
         div_divisor  = den_abs[DVS_W-1:0];
      end else begin
         div_dividend = DIV_W'(HEIGHT_NUM);
         div_divisor  = DVS_W'(corr_val);
      end
   end

   // Squared distance of the vertical hit, square root step.
   always_comb begin
      dv       = acc_ff + prod_ff[SQ_W-1:0];
      sq_trial = {1'b0, sres_ff} + {1'b0, sbit_ff};
      def_x    = (state_ff == S_IDLE) ? req.view_x : px_ff;
      def_y    = (state_ff == S_IDLE) ? req.view_y : py_ff;
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      px_in       = px_ff;       py_in      = py_ff;
      h_in        = h_ff;        ra_in      = ra_ff;       ray_in     = ray_ff;
      cx_in       = cx_ff;       cy_in      = cy_ff;       cz_in      = cz_ff;
      cq_in       = cq_ff;       cnt_in     = cnt_ff;      csel_in    = csel_ff;
      c_in        = c_ff;        s_in       = s_ff;        fc_in      = fc_ff;
      w_pm_in     = w_pm_ff;     w_po_in    = w_po_ff;
      w_num_in    = w_num_ff;    w_den_in   = w_den_ff;
      w_fwd_in    = w_fwd_ff;    w_horiz_in = w_horiz_ff;  w_neg_in   = w_neg_ff;
      w_line_in   = w_line_ff;   w_l_in     = w_l_ff;      w_k_in     = w_k_ff;
      o_in        = o_ff;
      hh_in       = hh_ff;       vh_in      = vh_ff;
      hx_in       = hx_ff;       hy_in      = hy_ff;
      vx_in       = vx_ff;       vy_in      = vy_ff;
      prod_in     = prod_ff;     acc_in     = acc_ff;      dh_in      = dh_ff;
      sv_in       = sv_ff;       sres_in    = sres_ff;     sbit_in    = sbit_ff;
      res_side_in = res_side_ff; res_x_in   = res_x_ff;    res_y_in   = res_y_ff;
      res_corr_in = res_corr_ff; res_h_in   = res_h_ff;
      do_adv      = 1'b0;

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept) begin
               px_in    = req.view_x;
               py_in    = req.view_y;
               h_in     = h_wrap;
               ra_in    = ra_first;
               ray_in   = '0;
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            cx_in  = nx;
            cy_in  = ny;
            cz_in  = nz;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               if (csel_ff) begin
                  fc_in    = fold_c;
                  state_in = S_CMUL;
               end else begin
                  c_in     = fold_c;
                  s_in     = fold_s;
                  state_in = S_HSET;
               end
            end
         end
         S_HSET, S_VSET: begin
            if ((state_ff == S_HSET) &&
                (ra_ff == '0 || ra_ff == HALF_TURN || s_ff == '0)) begin
               state_in = S_VSET;
            end else if ((state_ff == S_VSET) &&
                         (ra_ff == QUARTER_TURN || ra_ff == THREE_QUARTER || c_ff == '0)) begin
               state_in = S_DHX;
            end else begin
               w_horiz_in = (state_ff == S_HSET);
               w_pm_in    = ws_pm;
               w_po_in    = (state_ff == S_HSET) ? px_ff : py_ff;
               w_num_in   = (state_ff == S_HSET) ? c_ff : s_ff;
               w_den_in   = (state_ff == S_HSET) ? s_ff : c_ff;
               w_fwd_in   = ws_fwd;
               w_line_in  = LINE_W'(32'(ws_idx) * CELL_FIX + (ws_fwd ? CELL_FIX : 0));
               w_l_in     = LIDX_W'(ws_idx) + LIDX_W'(ws_fwd);
               w_k_in     = '0;
               state_in   = S_WSTEP;
            end
         end
         S_WSTEP: begin
            if (cm_ok) state_in = S_WMUL;
            else       do_adv   = 1'b1;
         end
         S_WMUL: begin
            prod_in  = mul_p;
            state_in = S_WDIVGO;
         end
         S_WDIVGO: begin
            w_neg_in = prod_ff[PROD_W-1] ^ w_den_ff[XY_W-1];
            state_in = S_WDIV;
         end
         S_WDIV: begin
            if (div_done) begin
               o_in     = q_signed + $signed({27'b0, w_po_ff});
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            if (o_ok && wall_bit) begin
               if (w_horiz_ff) begin
                  hh_in    = 1'b1;
                  hy_in    = w_line_ff[HIT_W-1:0];
                  hx_in    = o_ff[HIT_W-1:0];
                  state_in = S_VSET;
               end else begin
                  vh_in    = 1'b1;
                  vx_in    = w_line_ff[HIT_W-1:0];
                  vy_in    = o_ff[HIT_W-1:0];
                  state_in = S_DHX;
               end
            end else begin
               do_adv = 1'b1;
            end
         end
         S_DHX: begin
            prod_in  = mul_p;
            state_in = (hh_ff || vh_ff) ? S_DHY : S_OUT;
         end
         S_DHY: begin
            acc_in   = prod_ff[SQ_W-1:0];
            prod_in  = mul_p;
            state_in = S_DVX;
         end
         S_DVX: begin
            dh_in    = acc_ff + prod_ff[SQ_W-1:0];
            prod_in  = mul_p;
            state_in = S_DVY;
         end
         S_DVY: begin
            acc_in   = prod_ff[SQ_W-1:0];
            prod_in  = mul_p;
            state_in = S_PICK;
         end
         S_PICK: begin
            // Ties go to the horizontal hit.
            if (hh_ff && (!vh_ff || dh_ff <= dv)) begin
               res_side_in = SIDE_HORZ;
               res_x_in    = hx_ff;
               res_y_in    = hy_ff;
               sv_in       = dh_ff;
            end else begin
               res_side_in = SIDE_VERT;
               res_x_in    = vx_ff;
               res_y_in    = vy_ff;
               sv_in       = dv;
            end
            sres_in  = '0;
            sbit_in  = 32'h4000_0000;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if ({1'b0, sv_ff} >= sq_trial) begin
               sv_in   = sv_ff - sq_trial[SQ_W-1:0];
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) state_in = S_FISH;
         end
         S_FISH: begin
            state_in = S_CORD;
         end
         S_CMUL: begin
            prod_in  = mul_p;
            state_in = S_CORR;
         end
         S_CORR: begin
            res_corr_in = corr_val;
            if (corr_val == '0) begin
               res_h_in = HEIGHT_MAX;
               state_in = S_OUT;
            end else begin
               state_in = S_HDIV;
            end
         end
         S_HDIV: begin
            if (div_done) begin
               res_h_in = (div_quo > DIV_W'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quo[HGT_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               if (ray_ff == COL_W'(NUM_RAYS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  ray_in   = ray_ff + 1'b1;
                  ra_in    = ra_next;
                  state_in = S_CORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Next grid line, or end of this walk.
      if (do_adv) begin
         if (w_k_ff == K_W'(MAX_STEPS - 1)) begin
            state_in = w_horiz_ff ? S_VSET : S_DHX;
         end else begin
            w_line_in = w_fwd_ff ? w_line_ff + LINE_W'(CELL_FIX) : w_line_ff - LINE_W'(CELL_FIX);
            w_l_in    = w_fwd_ff ? w_l_ff + LIDX_W'(1) : w_l_ff - LIDX_W'(1);
            w_k_in    = w_k_ff + 1'b1;
            state_in  = S_WSTEP;
         end
      end

      // CORDIC launch, and per-column defaults at the start of a ray.
      if (cord_go) begin
         cx_in   = CORDIC_X0;
         cy_in   = '0;
         cz_in   = $signed({8'b0, cord_part} << 8);
         cq_in   = cord_q;
         cnt_in  = '0;
         csel_in = (state_ff == S_FISH);
      end
      if (ray_start) begin
         hh_in       = 1'b0;
         vh_in       = 1'b0;
         res_side_in = SIDE_NONE;
         res_x_in    = {4'b0, def_x};
         res_y_in    = {4'b0, def_y};
         res_corr_in = DIST_MAX;
         res_h_in    = '0;
      end
   end

   // Output register.
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wall_map_ff  <= WALL_MAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) wall_map_ff <= csr_wr_data;
      end
      px_ff <= px_in;   py_ff <= py_in;
      h_ff  <= h_in;    ra_ff <= ra_in;   ray_ff <= ray_in;
      cx_ff <= cx_in;   cy_ff <= cy_in;   cz_ff  <= cz_in;
      cq_ff <= cq_in;   cnt_ff <= cnt_in; csel_ff <= csel_in;
      c_ff  <= c_in;    s_ff  <= s_in;    fc_ff  <= fc_in;
      w_pm_ff   <= w_pm_in;   w_po_ff    <= w_po_in;
      w_num_ff  <= w_num_in;  w_den_ff   <= w_den_in;
      w_fwd_ff  <= w_fwd_in;  w_horiz_ff <= w_horiz_in; w_neg_ff <= w_neg_in;
      w_line_ff <= w_line_in; w_l_ff     <= w_l_in;     w_k_ff   <= w_k_in;
      o_ff      <= o_in;
      hh_ff <= hh_in;   vh_ff <= vh_in;
      hx_ff <= hx_in;   hy_ff <= hy_in;   vx_ff <= vx_in;   vy_ff <= vy_in;
      prod_ff <= prod_in; acc_ff <= acc_in; dh_ff <= dh_in;
      sv_ff <= sv_in;   sres_ff <= sres_in; sbit_ff <= sbit_in;
      res_side_ff <= res_side_in; res_x_ff <= res_x_in; res_y_ff <= res_y_in;
      res_corr_ff <= res_corr_in; res_h_ff <= res_h_in;
      if (load) begin
         rsp_column_ff <= ray_ff;
         rsp_side_ff   <= res_side_ff;
         rsp_x_ff      <= res_x_ff[POS_W-1:0];
         rsp_y_ff      <= res_y_ff[POS_W-1:0];
         rsp_corr_ff   <= res_corr_ff;
         rsp_h_ff      <= res_h_ff;
         rsp_top_ff    <= HALF_SCREEN - res_h_ff[HGT_W-1:1];
         rsp_last_ff   <= (ray_ff == COL_W'(NUM_RAYS - 1));
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.column             = rsp_column_ff;
   assign rsp.wall_side          = rsp_side_ff;
   assign rsp.hit_x              = rsp_x_ff;
   assign rsp.hit_y              = rsp_y_ff;
   assign rsp.corrected_distance = rsp_corr_ff;
   assign rsp.wall_height        = rsp_h_ff;
   assign rsp.wall_top           = rsp_top_ff;
   assign rsp.last               = rsp_last_ff;

endmodule

[verif/tb_grid_raycast_wall_columns.sv]
module tb_grid_raycast_wall_columns;
   import grwc_pkg::*;

   localparam int RAYS        = 60;
   localparam int STEPS       = 8;
   localparam int SIDE_CELLS  = 8;
   localparam longint CELL_FX = 1024;
   localparam int IDLE_LIMIT  = 20000;
   localparam int LONG_HOLD   = 2000;
   localparam logic [63:0] BORDER_MAP = 64'hFF818181818181FF;
   localparam logic [63:0] EMPTY_MAP  = 64'h0;
   localparam logic [63:0] SOLID_MAP  = 64'hFFFFFFFFFFFFFFFF;
   localparam logic [63:0] ONE_CELL   = 64'h0000000008000000;

   localparam int ARC [16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                               917, 458, 229, 115, 57, 29, 14, 7};

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [SIDE_W-1:0] wall_side;
      logic [POS_W-1:0]  hit_x;
      logic [POS_W-1:0]  hit_y;
      logic [DIST_W-1:0] distance;
      logic [HGT_W-1:0]  height;
      logic [TOP_W-1:0]  top;
      logic              last;
   } wall_column_type;

   typedef struct {
      logic [63:0] map;
      int          x;
      int          y;
      int          hdg;
      bit          all_miss;
   } view_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [63:0] csr_wr_data;

   grwc_req_if req_ch();
   grwc_rsp_if rsp_ch();

   grid_raycast_wall_columns DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   wall_column_type expected_columns[$];
   logic [63:0]  wall_bits;
   int  mismatches = 0;
   int  frames_sent = 0;
   int  columns_seen = 0;
   int  maps_loaded = 0;
   bit  gaps_on = 1'b0;
   bit  hold_go = 1'b0;

   // Directed views: extremes, axis rays, grid points, empty and solid maps.
   view_row_type plan[] = '{
      '{WALL_MAP_RESET, 0, 0, 0, 1'b0},
      '{WALL_MAP_RESET, 8191, 8191, 5759, 1'b0},
      '{WALL_MAP_RESET, 4000, 4000, 8191, 1'b0},
      '{WALL_MAP_RESET, 2048, 3072, 480, 1'b0},
      '{WALL_MAP_RESET, 3000, 2500, 1920, 1'b0},
      '{WALL_MAP_RESET, 1024, 1024, 3360, 1'b0},
      '{WALL_MAP_RESET, 5000, 6000, 2880, 1'b0},
      '{WALL_MAP_RESET, 100, 7000, 4800, 1'b0},
      '{WALL_MAP_RESET, 8191, 0, 4320, 1'b0},
      '{EMPTY_MAP, 4096, 4096, 1000, 1'b1},
      '{EMPTY_MAP, 0, 8191, 4321, 1'b1},
      '{SOLID_MAP, 4096, 4096, 2000, 1'b0},
      '{SOLID_MAP, 1500, 2700, 300, 1'b0},
      '{ONE_CELL, 3600, 3600, 0, 1'b0},
      '{ONE_CELL, 1000, 1000, 720, 1'b0}
   };

   // CORDIC sine and cosine in Q16, angle in sixteenths of a degree.
   function automatic void ray_sin_cos(input int unsigned a, output int co, output int si);
      int x, y, z, nx, ny;
      int unsigned q, part;
      a = a % 5760;
      q = a / 1440;
      part = a % 1440;
      z = int'(part * 256);
      x = 39797;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ARC[i];
         end
         x = nx;
         y = ny;
      end
      case (q)
         0: begin co = x;  si = y;  end
         1: begin co = -y; si = x;  end
         2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
   endfunction

   // Step across grid lines normal to the main axis until a wall cell is found.
   function automatic bit cross_lines(input longint pm, input longint po, input longint num,
                                      input longint den, input bit fwd, input bit horiz,
                                      output longint hm, output longint ho);
      longint line, cm, o, cc, row, col;
      line = (pm / CELL_FX) * CELL_FX;
      hm = 0;
      ho = 0;
      if (fwd) line += CELL_FX;
      for (int k = 0; k < STEPS; k++) begin
         cm = fwd ? line / CELL_FX : line / CELL_FX - 1;
         o = po + (line - pm) * num / den;
         if (o >= 0 && cm >= 0 && cm < SIDE_CELLS) begin
            cc = o / CELL_FX;
            if (cc < SIDE_CELLS) begin
               row = horiz ? cm : cc;
               col = horiz ? cc : cm;
               if (wall_bits[row * 8 + col]) begin
                  hm = line;
                  ho = o;
                  return 1'b1;
               end
            end
         end
         line += fwd ? CELL_FX : -CELL_FX;
      end
      return 1'b0;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned dist_sq(input longint ax, input longint ay,
                                               input longint bx, input longint by);
      longint unsigned dx, dy;
      dx = bx >= ax ? bx - ax : ax - bx;
      dy = by >= ay ? by - ay : ay - by;
      return dx * dx + dy * dy;
   endfunction

   // Work out the frame of columns that one view produces.
   function automatic void predict_frame(input int vx, input int vy, input int hdg);
      longint px, py, hx, hy, wx, wy, rx, ry;
      int unsigned h, ra;
      int c, s, cc, cs;
      bit hh, vh;
      longint unsigned dh, dv, d, corr, hgt;
      wall_column_type col;
      px = vx;
      py = vy;
      h = hdg % 5760;
      for (int r = 0; r < RAYS; r++) begin
         ra = (h + 5760 - 480 + 16 * r) % 5760;
         ray_sin_cos(ra, c, s);
         hh = 1'b0;
         vh = 1'b0;
         if (ra != 0 && ra != 2880 && s != 0)
            hh = cross_lines(py, px, c, s, ra < 2880, 1'b1, hy, hx);
         if (ra != 1440 && ra != 4320 && c != 0)
            vh = cross_lines(px, py, s, c, ra < 1440 || ra > 4320, 1'b0, wx, wy);
         col.column = COL_W'(r);
         col.last = (r == RAYS - 1);
         col.wall_side = SIDE_NONE;
         col.hit_x = POS_W'(vx);
         col.hit_y = POS_W'(vy);
         col.distance = DIST_MAX;
         col.height = '0;
         col.top = HALF_SCREEN;
         if (hh || vh) begin
            dh = hh ? dist_sq(px, py, hx, hy) : 0;
            dv = vh ? dist_sq(px, py, wx, wy) : 0;
            // Ties go to the horizontal line.
            if (hh && (!vh || dh <= dv)) begin
               col.wall_side = SIDE_HORZ; rx = hx; ry = hy; d = floor_sqrt(dh);
            end else begin
               col.wall_side = SIDE_VERT; rx = wx; ry = wy; d = floor_sqrt(dv);
            end
            ray_sin_cos(h + 5760 - ra, cc, cs);
            corr = cc > 0 ? (d * longint'(cc)) >> 16 : 0;
            if (corr > DIST_MAX) corr = DIST_MAX;
            if (corr == 0) hgt = HEIGHT_MAX;
            else begin
               hgt = 327680 / corr;
               if (hgt > HEIGHT_MAX) hgt = HEIGHT_MAX;
            end
            col.hit_x = rx[POS_W-1:0];
            col.hit_y = ry[POS_W-1:0];
            col.distance = DIST_W'(corr);
            col.height = HGT_W'(hgt);
            col.top = TOP_W'(HALF_SCREEN - hgt / 2);
         end
         expected_columns.push_back(col);
      end
   endfunction

   // A frame in which no ray meets a wall, typed in directly.
   function automatic void expect_blank_frame(input int vx, input int vy);
      wall_column_type col;
      for (int r = 0; r < RAYS; r++) begin
         col = '{column: COL_W'(r), wall_side: SIDE_NONE, hit_x: POS_W'(vx),
                 hit_y: POS_W'(vy), distance: DIST_MAX, height: '0, top: HALF_SCREEN,
                 last: r == RAYS - 1};
         expected_columns.push_back(col);
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      if (mismatches < 30)
         $display("mismatch in %s: got %0d, expected %0d", field, got, want);
      mismatches++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one view; returns at the falling edge after it was taken.
   task automatic send_view(input int vx, input int vy, input int hdg, input bit blank);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.view_x <= vx;
      req_ch.view_y <= vy;
      req_ch.heading <= hdg;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (blank) expect_blank_frame(vx, vy);
      else predict_frame(vx, vy, hdg);
      frames_sent++;
      @(negedge clock);
   endtask

   // Load a new wall bitmap once the block has drained.
   task automatic load_map(input logic [63:0] m);
      req_ch.valid <= 1'b0;
      while (expected_columns.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      wall_bits = m;
      maps_loaded++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Receiver: short random stalls, and one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_go = 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each column leaving the block with the oldest expectation.
   always @(posedge clock) begin
      wall_column_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         columns_seen++;
         if (expected_columns.size() == 0) begin
            report_mismatch("unexpected column", rsp_ch.column, -1);
         end else begin
            want = expected_columns.pop_front();
            if (rsp_ch.column !== want.column)
               report_mismatch("column", rsp_ch.column, want.column);
            if (rsp_ch.wall_side !== want.wall_side)
               report_mismatch("wall_side", rsp_ch.wall_side, want.wall_side);
            if (rsp_ch.hit_x !== want.hit_x)
               report_mismatch("hit_x", rsp_ch.hit_x, want.hit_x);
            if (rsp_ch.hit_y !== want.hit_y)
               report_mismatch("hit_y", rsp_ch.hit_y, want.hit_y);
            if (rsp_ch.corrected_distance !== want.distance)
               report_mismatch("corrected_distance", rsp_ch.corrected_distance, want.distance);
            if (rsp_ch.wall_height !== want.height)
               report_mismatch("wall_height", rsp_ch.wall_height, want.height);
            if (rsp_ch.wall_top !== want.top)
               report_mismatch("wall_top", rsp_ch.wall_top, want.top);
            if (rsp_ch.last !== want.last)
               report_mismatch("last", rsp_ch.last, want.last);
         end
      end
   end

   // Watchdog on cycles without any item moving.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] maps [6];
      int counts [6];
      int vx, vy, hdg;
      req_ch.valid = 1'b0;
      req_ch.view_x = '0;
      req_ch.view_y = '0;
      req_ch.heading = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      wall_bits = WALL_MAP_RESET;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows, in order, reloading the map where a row asks for another.
      foreach (plan[i]) begin
         if (plan[i].map != wall_bits) load_map(plan[i].map);
         send_view(plan[i].x, plan[i].y, plan[i].hdg, plan[i].all_miss);
      end

      // Random views over several maps; the last phase runs without gaps.
      maps = '{BORDER_MAP | {$urandom, $urandom}, {$urandom, $urandom}, SOLID_MAP,
               {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom},
               BORDER_MAP, WALL_MAP_RESET};
      counts = '{25, 25, 20, 10, 25, 20};
      for (int p = 0; p < 6; p++) begin
         load_map(maps[p]);
         gaps_on = (p != 5);
         for (int n = 0; n < counts[p]; n++) begin
            if (p == 0 && n == 5) hold_go = 1'b1;
            vx = $urandom_range(0, 3) == 0 ? 1024 * $urandom_range(0, 7)
                                          : $urandom_range(0, 8191);
            vy = $urandom_range(0, 3) == 0 ? 1024 * $urandom_range(0, 7)
                                          : $urandom_range(0, 8191);
            case ($urandom_range(0, 5))
               0: hdg = $urandom_range(5760, 8191);
               1: hdg = 16 * $urandom_range(0, 359);
               default: hdg = $urandom_range(0, 5759);
            endcase
            send_view(vx, vy, hdg, 1'b0);
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_columns.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Ran %0d views over %0d wall maps, %0d columns checked.",
               frames_sent, maps_loaded + 1, columns_seen);
      $display("Covered axis rays, grid points, empty and solid maps, and a long output stall.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
